>>> rtl/table_driven_fsm_engine_defines.svh
// Assertion macros shared by the table-driven FSM engine.
// Included by the top level only; no other dependencies.
`ifndef TABLE_DRIVEN_FSM_ENGINE_DEFINES_SVH
`define TABLE_DRIVEN_FSM_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TDF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tdf_pkg.sv
// Package for the table-driven FSM engine: defaults, opcodes, row kinds,
// controller state type and the controller/datapath command and status structs.
package tdf_pkg;

   localparam int DEF_NUM_STATES     = 16;
   localparam int DEF_ROWS_PER_STATE = 8;
   localparam int DEF_LABEL_BITS     = 16;
   localparam int DEF_ACTION_BITS    = 8;

   localparam int OPCODE_BITS = 2;
   localparam int KIND_BITS   = 2;

   localparam logic [OPCODE_BITS-1:0] OP_EVENT = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_WRITE = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_COUNT = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_RESET = 2'd3;

   localparam logic [KIND_BITS-1:0] KIND_NEW        = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_IGNORE     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_IMPOSSIBLE = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } tdf_state_type;

   // controller -> datapath
   typedef struct packed {
      logic ready;        // request port ready
      logic accept;       // request taken this cycle
      logic load_direct;  // result produced at accept
      logic scan_start;   // event with rows: first row read issued
      logic scan_step;    // one row checked this cycle
   } tdf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_valid;
      logic out_free;     // result register empty or being drained
      logic is_event;
      logic count_zero;   // current state has no rows
      logic scan_done;    // row matched or last row reached
   } tdf_status_type;

endpackage

>>> rtl/tdf_req_if.sv
// Request channel of the table-driven FSM engine: valid/ready plus fields.
// Depends on tdf_pkg for defaults.
interface tdf_req_if import tdf_pkg::*; #(
   parameter int STATE_BITS  = 4,
   parameter int SLOT_BITS   = 3,
   parameter int COUNT_BITS  = 4,
   parameter int LABEL_BITS  = DEF_LABEL_BITS,
   parameter int ACTION_BITS = DEF_ACTION_BITS
);
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [LABEL_BITS-1:0]  event_label;
   logic [STATE_BITS-1:0]  target_state;
   logic [SLOT_BITS-1:0]   row_slot;
   logic [LABEL_BITS-1:0]  row_label;
   logic [KIND_BITS-1:0]   row_kind;
   logic [STATE_BITS-1:0]  row_next_state;
   logic [ACTION_BITS-1:0] row_action;
   logic [COUNT_BITS-1:0]  row_total;

   modport source (
      output valid, opcode, event_label, target_state, row_slot, row_label,
             row_kind, row_next_state, row_action, row_total,
      input  ready
   );
   modport sink (
      input  valid, opcode, event_label, target_state, row_slot, row_label,
             row_kind, row_next_state, row_action, row_total,
      output ready
   );
endinterface

>>> rtl/tdf_rsp_if.sv
// Response channel of the table-driven FSM engine: valid/ready plus fields.
// Depends on tdf_pkg for defaults.
interface tdf_rsp_if import tdf_pkg::*; #(
   parameter int STATE_BITS  = 4,
   parameter int ACTION_BITS = DEF_ACTION_BITS
);
   logic                   valid;
   logic                   ready;
   logic                   handled;
   logic                   action_fire;
   logic [ACTION_BITS-1:0] action_id;
   logic [STATE_BITS-1:0]  state_now;

   modport source (
      output valid, handled, action_fire, action_id, state_now,
      input  ready
   );
   modport sink (
      input  valid, handled, action_fire, action_id, state_now,
      output ready
   );
endinterface

>>> rtl/tdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdf_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 128,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/tdf_ctrl.sv
// Controller of the table-driven FSM engine: idle / row-scan sequencing.
// Depends on tdf_pkg (state type, command and status structs).
module tdf_ctrl import tdf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tdf_status_type status,
   output tdf_cmd_type    cmd
);
   tdf_state_type state_ff, state_in;
   logic          scan_needed;

   assign scan_needed = status.is_event && !status.count_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && scan_needed) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready       = status.out_free;
            cmd.accept      = status.out_free && status.req_valid;
            cmd.load_direct = cmd.accept && !scan_needed;
            cmd.scan_start  = cmd.accept && scan_needed;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         default: cmd = '0;
      endcase
   end
endmodule

>>> rtl/tdf_dpath.sv
// Datapath of the table-driven FSM engine: current state, row counts,
// row RAM, scan registers and result register. Depends on tdf_pkg, tdf_ram.
module tdf_dpath import tdf_pkg::*; #(
   parameter int NUM_STATES     = DEF_NUM_STATES,
   parameter int ROWS_PER_STATE = DEF_ROWS_PER_STATE,
   parameter int LABEL_BITS     = DEF_LABEL_BITS,
   parameter int ACTION_BITS    = DEF_ACTION_BITS,
   localparam int STATE_BITS    = $clog2(NUM_STATES),
   localparam int SLOT_BITS     = (ROWS_PER_STATE > 1) ? $clog2(ROWS_PER_STATE) : 1,
   localparam int COUNT_BITS    = $clog2(ROWS_PER_STATE + 1)
) (
   input  logic           clock,
   input  logic           reset,
   tdf_req_if.sink        req_if,
   tdf_rsp_if.source      rsp_if,
   input  tdf_cmd_type    cmd,
   output tdf_status_type status
);
   localparam int ROW_BITS  = LABEL_BITS + KIND_BITS + STATE_BITS + ACTION_BITS;
   localparam int ADDR_BITS = STATE_BITS + SLOT_BITS;
   localparam int POS_BITS  = SLOT_BITS + 1;
   localparam int RAM_DEPTH = NUM_STATES << SLOT_BITS;

   logic [STATE_BITS-1:0]  cur_state_ff;
   logic [COUNT_BITS-1:0]  row_count_ff [NUM_STATES];
   logic [LABEL_BITS-1:0]  ev_label_ff;
   logic [SLOT_BITS-1:0]   idx_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_handled_ff, rsp_handled_in;
   logic                   rsp_fire_ff, rsp_fire_in;
   logic [ACTION_BITS-1:0] rsp_action_ff, rsp_action_in;
   logic [STATE_BITS-1:0]  rsp_state_ff, rsp_state_in;
   logic [STATE_BITS-1:0]  cur_state_in;

   logic                   tgt_ok, slot_ok, wr_en, rd_en;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
   logic [ROW_BITS-1:0]    wr_data, rd_data;
   logic [COUNT_BITS-1:0]  total_sat, cur_count;
   logic [SLOT_BITS-1:0]   idx_next;
   logic [POS_BITS-1:0]    scan_pos;

   logic [LABEL_BITS-1:0]  rd_label;
   logic [KIND_BITS-1:0]   rd_kind;
   logic [STATE_BITS-1:0]  rd_next, rd_next_sat;
   logic [ACTION_BITS-1:0] rd_action;
   logic                   row_match, row_last, scan_done, finish;

   // request decode
   assign tgt_ok  = (POS_BITS + STATE_BITS)'(req_if.target_state)
                  < (POS_BITS + STATE_BITS)'(NUM_STATES);
   assign slot_ok = POS_BITS'(req_if.row_slot) < POS_BITS'(ROWS_PER_STATE);
   assign total_sat = (req_if.row_total > COUNT_BITS'(ROWS_PER_STATE))
                    ? COUNT_BITS'(ROWS_PER_STATE) : req_if.row_total;
   assign cur_count = row_count_ff[cur_state_ff];

   // row RAM: {label, kind, next state, action}
   assign wr_en   = cmd.accept && (req_if.opcode == OP_WRITE) && tgt_ok && slot_ok;
   assign wr_addr = {req_if.target_state, req_if.row_slot};
   assign wr_data = {req_if.row_label, req_if.row_kind, req_if.row_next_state,
                     req_if.row_action};
   assign idx_next = idx_ff + SLOT_BITS'(1);
   assign rd_en    = cmd.scan_start || cmd.scan_step;
   assign rd_addr  = cmd.scan_start ? {cur_state_ff, SLOT_BITS'(0)}
                                    : {cur_state_ff, idx_next};

   tdf_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign {rd_label, rd_kind, rd_next, rd_action} = rd_data;
   assign rd_next_sat = ((POS_BITS + STATE_BITS)'(rd_next)
                         >= (POS_BITS + STATE_BITS)'(NUM_STATES))
                      ? STATE_BITS'(NUM_STATES - 1) : rd_next;

   // scan compare
   assign row_match = (rd_label == ev_label_ff);
   assign scan_pos  = POS_BITS'(idx_ff) + POS_BITS'(1);
   assign row_last  = (scan_pos == POS_BITS'(cnt_ff));
   assign scan_done = row_match || row_last;
   assign finish    = cmd.scan_step && scan_done;

   // result and next current state
   always_comb begin
      rsp_handled_in = 1'b0;
      rsp_fire_in    = 1'b0;
      rsp_action_in  = '0;
      cur_state_in   = cur_state_ff;
      if (cmd.load_direct) begin
         if (req_if.opcode == OP_RESET) begin
            cur_state_in = '0;
         end
      end else if (finish && row_match) begin
         case (rd_kind)
            KIND_NEW: begin
               rsp_handled_in = 1'b1;
               cur_state_in   = rd_next_sat;
               rsp_fire_in    = (rd_action != '0);
               rsp_action_in  = rd_action;
            end
            KIND_IMPOSSIBLE: rsp_handled_in = 1'b0;
            default:         rsp_handled_in = 1'b1;
         endcase
      end
      rsp_state_in = cur_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STATES; i++) begin
            row_count_ff[i] <= '0;
         end
      end else begin
         cur_state_ff <= cur_state_in;
         if (cmd.accept && (req_if.opcode == OP_COUNT) && tgt_ok) begin
            row_count_ff[req_if.target_state] <= total_sat;
         end
         if (cmd.load_direct || finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         ev_label_ff <= req_if.event_label;
         cnt_ff      <= cur_count;
         idx_ff      <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_next;
      end
      if (cmd.load_direct || finish) begin
         rsp_handled_ff <= rsp_handled_in;
         rsp_fire_ff    <= rsp_fire_in;
         rsp_action_ff  <= rsp_action_in;
         rsp_state_ff   <= rsp_state_in;
      end
   end

   assign req_if.ready       = cmd.ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.handled     = rsp_handled_ff;
   assign rsp_if.action_fire = rsp_fire_ff;
   assign rsp_if.action_id   = rsp_action_ff;
   assign rsp_if.state_now   = rsp_state_ff;

   assign status.req_valid  = req_if.valid;
   assign status.out_free   = !rsp_valid_ff || rsp_if.ready;
   assign status.is_event   = (req_if.opcode == OP_EVENT);
   assign status.count_zero = (cur_count == '0);
   assign status.scan_done  = scan_done;
endmodule

>>> rtl/table_driven_fsm_engine.sv
// Channel   Dir  Handshake     Payload
// req_if    in   valid/ready   opcode, event/row labels, target, slot, kind, next, action, total
// rsp_if    out  valid/ready   handled, action_fire, action_id, state_now
//
// One request is in flight at a time. Row writes, row-count writes, state
// reset and events on a state with no rows produce their response in the
// cycle after acceptance. An event scans the current state's rows through
// the row RAM's single read port, one row per cycle, at most ROWS_PER_STATE
// rows in all. A new request is taken while the previous response is being
// drained. Synchronous active-high reset clears the state and all row counts;
// row contents are undefined until written.
//
// Top level of the table-driven FSM engine. Depends on tdf_pkg, the channel
// interfaces, tdf_ctrl, tdf_dpath, tdf_ram and the assertion macro header.
`include "table_driven_fsm_engine_defines.svh"

module table_driven_fsm_engine import tdf_pkg::*; #(
   parameter int NUM_STATES     = DEF_NUM_STATES,
   parameter int ROWS_PER_STATE = DEF_ROWS_PER_STATE,
   parameter int LABEL_BITS     = DEF_LABEL_BITS,
   parameter int ACTION_BITS    = DEF_ACTION_BITS
) (
   input  logic      clock,
   input  logic      reset,
   tdf_req_if.sink   req_if,
   tdf_rsp_if.source rsp_if
);
   localparam int STATE_BITS = $clog2(NUM_STATES);

   tdf_cmd_type    ctl_cmd;
   tdf_status_type ctl_status;

   // sequencer: decides when requests are taken and when a scan runs
   tdf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (ctl_status),
      .cmd    (ctl_cmd)
   );

   // state, row store, scan compare and response register
   tdf_dpath #(
      .NUM_STATES     (NUM_STATES),
      .ROWS_PER_STATE (ROWS_PER_STATE),
      .LABEL_BITS     (LABEL_BITS),
      .ACTION_BITS    (ACTION_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (ctl_cmd),
      .status (ctl_status)
   );

   // ready only when the response register can take the result
   `TDF_ASSERT_SAME(a_ready_out_free, clock, reset, req_if.ready, (!rsp_if.valid || rsp_if.ready), "request ready while response register is blocked")
   // non-event requests answer on the next cycle
   `TDF_ASSERT_NEXT(a_direct_rsp, clock, reset, (req_if.valid && req_if.ready && req_if.opcode != OP_EVENT), rsp_if.valid, "missing response after non-event request")
   // no new request during a row scan
   `TDF_ASSERT_SAME(a_no_accept_scan, clock, reset, ctl_cmd.scan_step, !req_if.ready, "request ready during row scan")
   // reported state always a legal state
   `TDF_ASSERT_SAME(a_state_range, clock, reset, rsp_if.valid, ((STATE_BITS + 1)'(rsp_if.state_now) < (STATE_BITS + 1)'(NUM_STATES)), "state_now out of range")
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the table-driven FSM engine: directed and random
// requests, a scoreboard of predicted responses. Depends on tdf_pkg and the
// tdf_req_if / tdf_rsp_if channel interfaces.
module testbench;
   import tdf_pkg::*;

   // Widths follow the engine's default configuration.
   localparam int N_STATES = DEF_NUM_STATES;
   localparam int N_ROWS   = DEF_ROWS_PER_STATE;
   localparam int LBL_W    = DEF_LABEL_BITS;
   localparam int ACT_W    = DEF_ACTION_BITS;
   localparam int STATE_W  = 4;
   localparam int SLOT_W   = 3;
   localparam int COUNT_W  = 4;

   // Row kind 3 has no name in the package; a match on it counts as handled
   // and leaves the state alone.
   localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

   localparam int POOL_SIZE    = 6;      // labels shared by rows and events
   localparam int MIXED_COUNT  = 610;    // random requests after the table load
   localparam int IDLE_PCT     = 35;
   localparam int BURST_FIRST  = 2500;   // cycle window with no idling on either side
   localparam int BURST_LAST   = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic [OPCODE_BITS-1:0] opcode;
      logic [LBL_W-1:0]       event_label;
      logic [STATE_W-1:0]     target_state;
      logic [SLOT_W-1:0]      row_slot;
      logic [LBL_W-1:0]       row_label;
      logic [KIND_BITS-1:0]   row_kind;
      logic [STATE_W-1:0]     row_next_state;
      logic [ACT_W-1:0]       row_action;
      logic [COUNT_W-1:0]     row_total;
   } fsm_request_type;

   typedef struct {
      logic               handled;
      logic               action_fire;
      logic [ACT_W-1:0]   action_id;
      logic [STATE_W-1:0] state_now;
   } fsm_outcome_type;

   typedef struct packed {
      logic [LBL_W-1:0]     label;
      logic [KIND_BITS-1:0] kind;
      logic [STATE_W-1:0]   next;
      logic [ACT_W-1:0]     action;
   } fsm_row_type;

   logic clock;
   logic reset = 1'b1;

   tdf_req_if req_if ();
   tdf_rsp_if rsp_if ();

   table_driven_fsm_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the engine: current state, row table, row counts.
   // ---------------------------------------------------------------------
   logic [STATE_W-1:0] engine_state = '0;
   fsm_row_type        table_rows [N_STATES][N_ROWS];
   logic [COUNT_W-1:0] row_totals [N_STATES] = '{default: '0};

   // Requests waiting to be driven, responses waiting to arrive.
   fsm_request_type request_backlog [$];
   fsm_outcome_type expected_outcomes [$];

   // Generator's view of which rows hold data; keeps every scan on written rows.
   bit                 row_written [N_STATES][N_ROWS];
   logic [LBL_W-1:0]   label_pool [POOL_SIZE];

   int cycle_count    = 0;
   int mismatch_count = 0;

   wire no_idling = (cycle_count >= BURST_FIRST) && (cycle_count < BURST_LAST);

   // Applies one accepted request to the shadow engine and returns the
   // response it must produce.
   function automatic fsm_outcome_type run_engine_request(input fsm_request_type rq);
      fsm_outcome_type res;
      fsm_row_type     rw;
      bit              decided;
      res = '{handled: 1'b0, action_fire: 1'b0, action_id: '0, state_now: '0};
      decided = 1'b0;
      case (rq.opcode)
         OP_EVENT: begin
            // First row in slot order with an equal label decides; the
            // decided flag also stops the scan once the state has moved.
            for (int i = 0; i < N_ROWS; i++) begin
               rw = table_rows[engine_state][i];
               if (!decided && i < row_totals[engine_state] &&
                   rw.label == rq.event_label) begin
                  decided = 1'b1;
                  if (rw.kind != KIND_IMPOSSIBLE) res.handled = 1'b1;
                  if (rw.kind == KIND_NEW) begin
                     // a 4-bit next state is always in range, no saturation
                     engine_state = rw.next;
                     if (rw.action != '0) begin
                        res.action_fire = 1'b1;
                        res.action_id   = rw.action;
                     end
                  end
               end
            end
         end
         OP_WRITE: begin
            table_rows[rq.target_state][rq.row_slot] = '{label:  rq.row_label,
                                                         kind:   rq.row_kind,
                                                         next:   rq.row_next_state,
                                                         action: rq.row_action};
         end
         OP_COUNT: begin
            row_totals[rq.target_state] = (rq.row_total > N_ROWS) ?
                                          COUNT_W'(N_ROWS) : rq.row_total;
         end
         default: begin
            engine_state = '0;
         end
      endcase
      res.state_now = engine_state;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Every field random; the fields the opcode does not use stay as noise.
   function automatic fsm_request_type scrambled_request(input logic [OPCODE_BITS-1:0] op);
      fsm_request_type rq;
      rq.opcode         = op;
      rq.event_label    = LBL_W'($urandom);
      rq.target_state   = STATE_W'($urandom);
      rq.row_slot       = SLOT_W'($urandom);
      rq.row_label      = LBL_W'($urandom);
      rq.row_kind       = KIND_BITS'($urandom);
      rq.row_next_state = STATE_W'($urandom);
      rq.row_action     = ACT_W'($urandom);
      rq.row_total      = COUNT_W'($urandom);
      return rq;
   endfunction

   // Largest row count that keeps the scan on written rows. A requested total
   // that is already safe passes through untouched, saturating values included.
   function automatic logic [COUNT_W-1:0] covered_total(input int st,
                                                        input logic [COUNT_W-1:0] t);
      int eff;
      int run;
      eff = (t > N_ROWS) ? N_ROWS : int'(t);
      run = 0;
      while (run < N_ROWS && row_written[st][run]) run++;
      return (eff <= run) ? t : COUNT_W'(run);
   endfunction

   task automatic queue_request(input fsm_request_type rq);
      if (rq.opcode == OP_WRITE) row_written[rq.target_state][rq.row_slot] = 1'b1;
      if (rq.opcode == OP_COUNT) rq.row_total = covered_total(rq.target_state, rq.row_total);
      request_backlog.push_back(rq);
   endtask

   task automatic queue_event(input logic [LBL_W-1:0] label);
      fsm_request_type rq;
      rq = scrambled_request(OP_EVENT);
      rq.event_label = label;
      queue_request(rq);
   endtask

   task automatic queue_row(input logic [STATE_W-1:0] st, input logic [SLOT_W-1:0] sl,
                            input logic [LBL_W-1:0] label, input logic [KIND_BITS-1:0] kind,
                            input logic [STATE_W-1:0] next, input logic [ACT_W-1:0] action);
      fsm_request_type rq;
      rq = scrambled_request(OP_WRITE);
      rq.target_state   = st;
      rq.row_slot       = sl;
      rq.row_label      = label;
      rq.row_kind       = kind;
      rq.row_next_state = next;
      rq.row_action     = action;
      queue_request(rq);
   endtask

   task automatic queue_count(input logic [STATE_W-1:0] st, input logic [COUNT_W-1:0] t);
      fsm_request_type rq;
      rq = scrambled_request(OP_COUNT);
      rq.target_state = st;
      rq.row_total    = t;
      queue_request(rq);
   endtask

   function automatic logic [LBL_W-1:0] pool_label();
      return label_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Mostly transitions, the rest split over ignore, impossible and spare.
   function automatic logic [KIND_BITS-1:0] weighted_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return KIND_NEW;
      if (roll < 75) return KIND_IGNORE;
      if (roll < 90) return KIND_IMPOSSIBLE;
      return KIND_SPARE;
   endfunction

   // A quarter of the transitions carry no action.
   function automatic logic [ACT_W-1:0] random_action();
      return ($urandom_range(0, 3) == 0) ? '0 : ACT_W'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Clock, cycle counter, timeout
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: the request at the head of the backlog is on the bus
   // while valid is high; it is popped and predicted when accepted. Valid is
   // only reconsidered when the bus is empty or the request was just taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      fsm_request_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_outcomes.push_back(run_engine_request(request_backlog.pop_front()));
         end
         if (!req_if.valid || req_if.ready) begin
            if (request_backlog.size() != 0 &&
                (no_idling || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = request_backlog[0];
               req_if.valid          <= 1'b1;
               req_if.opcode         <= nxt.opcode;
               req_if.event_label    <= nxt.event_label;
               req_if.target_state   <= nxt.target_state;
               req_if.row_slot       <= nxt.row_slot;
               req_if.row_label      <= nxt.row_label;
               req_if.row_kind       <= nxt.row_kind;
               req_if.row_next_state <= nxt.row_next_state;
               req_if.row_action     <= nxt.row_action;
               req_if.row_total      <= nxt.row_total;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response side back-pressure, random per cycle outside the burst window.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= no_idling || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: every accepted response is matched against the
   // oldest prediction, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      fsm_outcome_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_if.handled !== want.handled || rsp_if.action_fire !== want.action_fire ||
                rsp_if.action_id !== want.action_id || rsp_if.state_now !== want.state_now) begin
               report_mismatch($sformatf(
                  "handled %b/%b fire %b/%b action %h/%h state %0d/%0d (got/want)",
                  rsp_if.handled, want.handled, rsp_if.action_fire, want.action_fire,
                  rsp_if.action_id, want.action_id, rsp_if.state_now, want.state_now));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int roll;

      // known values on every input before the first edge
      req_if.valid          = 1'b0;
      req_if.opcode         = OP_EVENT;
      req_if.event_label    = '0;
      req_if.target_state   = '0;
      req_if.row_slot       = '0;
      req_if.row_label      = '0;
      req_if.row_kind       = KIND_NEW;
      req_if.row_next_state = '0;
      req_if.row_action     = '0;
      req_if.row_total      = '0;
      rsp_if.ready          = 1'b0;

      for (int i = 0; i < POOL_SIZE; i++) label_pool[i] = LBL_W'($urandom);

      // --- directed: corner cases on state 0 ---
      queue_event(16'h0000);                 // no rows: not handled
      queue_event(16'hFFFF);
      queue_row(4'd0, 3'd0, 16'h0000, KIND_NEW,        4'd15, 8'hFF);
      queue_row(4'd0, 3'd1, 16'hFFFF, KIND_IGNORE,     4'd4,  8'h33);
      queue_row(4'd0, 3'd2, 16'h1234, KIND_IMPOSSIBLE, 4'd6,  8'h44);
      queue_row(4'd0, 3'd3, 16'h1234, KIND_NEW,        4'd3,  8'h05); // shadowed
      queue_row(4'd0, 3'd4, 16'h00AA, KIND_SPARE,      4'd7,  8'h09);
      queue_row(4'd0, 3'd5, 16'h0055, KIND_NEW,        4'd0,  8'h00); // no action
      queue_row(4'd0, 3'd6, 16'h0F0F, KIND_NEW,        4'd1,  8'h80);
      queue_row(4'd0, 3'd7, 16'h0000, KIND_NEW,        4'd2,  8'h01); // duplicate label
      queue_count(4'd0, 4'd15);              // saturates to a full row list
      queue_event(16'hFFFF);                 // ignore row
      queue_event(16'h1234);                 // impossible row hides a later match
      queue_event(16'h00AA);                 // spare kind: handled, no move
      queue_event(16'h0055);                 // self loop without action
      queue_event(16'hBEEF);                 // no match
      queue_event(16'h0000);                 // first of two equal labels wins
      queue_event(16'h0000);                 // state 15 has no rows
      queue_request(scrambled_request(OP_RESET));
      queue_count(4'd0, 4'd2);
      queue_event(16'h0F0F);                 // row beyond the count is not seen
      queue_count(4'd0, 4'd8);
      queue_event(16'h0F0F);
      queue_request(scrambled_request(OP_RESET));

      // --- random: load a full table from the label pool ---
      for (int st = 0; st < N_STATES; st++) begin
         for (int sl = 0; sl < N_ROWS; sl++) begin
            queue_row(STATE_W'(st), SLOT_W'(sl), pool_label(), weighted_kind(),
                      STATE_W'($urandom), random_action());
         end
         queue_count(STATE_W'(st), COUNT_W'($urandom));
      end

      // --- random: mostly events that hit the table, some reprogramming ---
      for (int n = 0; n < MIXED_COUNT; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            queue_event(pool_label());
         end else if (roll < 78) begin
            queue_event(LBL_W'($urandom));
         end else if (roll < 86) begin
            queue_row(STATE_W'($urandom), SLOT_W'($urandom), pool_label(), weighted_kind(),
                      STATE_W'($urandom), random_action());
         end else if (roll < 93) begin
            queue_count(STATE_W'($urandom), COUNT_W'($urandom));
         end else if (roll < 97) begin
            queue_request(scrambled_request(OP_RESET));
         end else begin
            // noise: arbitrary row contents, usually unreachable labels
            queue_request(scrambled_request(OP_WRITE));
         end
      end

      // hold reset, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/tdf_pkg.sv
rtl/tdf_req_if.sv
rtl/tdf_rsp_if.sv
rtl/tdf_ram.sv
rtl/tdf_ctrl.sv
rtl/tdf_dpath.sv
rtl/table_driven_fsm_engine.sv
sim/testbench.sv
